// ----- rtl/core/ldac_pkg.sv -----
// Package: constants, tables and types for the log-domain audio compressor.
`timescale 1ns / 1ps
package ldac_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic signed [16:0] DB_FLOOR    = -17'sd30720;
    localparam logic [15:0]        RED_MAX     = 16'd30720;
    localparam logic [31:0]        DB_PER_LOG2 = 32'd394566;
    localparam logic [31:0]        LOG2_PER_DB = 32'd10885;

    localparam logic [30:0] POW_TAB [16] = '{
        31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
        31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
        31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544,
        31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
    };

    typedef enum logic [2:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_SLOPE     = 3'd1,
        CFG_MAKEUP    = 3'd2,
        CFG_ATTACK    = 3'd3,
        CFG_RELEASE   = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_NORM, S_SQ_M, S_SQ_U, S_LVL_M, S_LVL_U, S_TGT_M, S_TGT_U,
        S_SM1_M, S_SM2_M, S_SM_U, S_GAIN_M, S_GAIN_U, S_POW_M, S_POW_U,
        S_OUT_M, S_OUT_U
    } t_state;

endpackage

// ----- rtl/core/ldac_if.sv -----
// Interfaces: sample input, result output and register write channels.
`timescale 1ns / 1ps
interface ldac_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_in;
    logic [2:0]         channel_in;
    modport source (output valid, sample_in, channel_in, input ready);
    modport sink (input valid, sample_in, channel_in, output ready);
endinterface

interface ldac_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_out;
    logic [2:0]         channel_out;
    logic [14:0]        reduction_db;
    modport source (output valid, sample_out, channel_out, reduction_db, input ready);
    modport sink (input valid, sample_out, channel_out, reduction_db, output ready);
endinterface

interface ldac_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/log_domain_audio_compressor.sv -----
// Feedforward log-domain compressor with per-channel gain smoothing.
//
// One sample is taken at a time. Samples of magnitude below 9 skip the log.
// The leading-one search shifts the 24-bit magnitude left once per leading
// zero, up to 20 times. The next sample can be taken in idle, which the
// sequencer enters when the result is loaded, so a sample holds the block
// until its result is loaded. All arithmetic runs through one registered
// 32x32 multiplier, driven by a sequencer. The sequencer runs 16 squaring
// steps for the log and 16 steps of the power table for the antilog. It
// uses two products for the smoothing and one each for the level, target,
// gain and output. The input is ready only in idle. A finished result waits
// in an output register while the next sample is taken. If a result is
// still waiting when the next one is finished, the sequencer holds until
// the output transfer. Register writes are taken at any time but must only
// happen while the block is idle.
`timescale 1ns / 1ps
module log_domain_audio_compressor
    import ldac_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ldac_in_if.sink      i_in,
    ldac_out_if.source   o_out,
    ldac_cfg_if.sink     i_cfg
);

    t_state r_state, n_state;

    logic signed [15:0] r_thr;
    logic [15:0]        r_slope;
    logic signed [13:0] r_makeup;
    logic [15:0]        r_attack;
    logic [15:0]        r_release;
    logic [15:0]        mem [CHANNELS];

    logic               r_neg;
    logic [23:0]        r_mag;
    logic [23:0]        r_norm;
    logic [4:0]         r_sh;
    logic [2:0]         r_ch;
    logic [15:0]        r_prev;
    logic [15:0]        r_x;
    logic [15:0]        r_frac;
    logic [3:0]         r_cnt;
    logic signed [16:0] r_lvl;
    logic               r_ge;
    logic [15:0]        r_t;
    logic [15:0]        r_coef;
    logic [63:0]        r_acc;
    logic [15:0]        r_red;
    logic               r_gneg;
    logic signed [5:0]  r_n;
    logic [15:0]        r_f16;
    logic [30:0]        r_p;
    logic [63:0]        r_prod;

    logic               r_out_valid;
    logic signed [23:0] r_out_sample;
    logic [2:0]         r_out_ch;
    logic [14:0]        r_out_red;

    logic [31:0]        mul_a, mul_b;
    logic               in_ready;
    logic               out_load;

    logic [23:0]        in_mag;
    logic [CH_AW-1:0]   in_idx, ch_idx;
    logic [16:0]        sq_y;
    logic [15:0]        sl;
    logic [16:0]        ex;
    logic [15:0]        coef;
    logic signed [17:0] g;
    logic [17:0]        g_mag;
    logic [31:0]        pl;
    logic [20:0]        neg_l;
    logic [15:0]        tgt;
    logic [15:0]        red;
    logic [5:0]         sh_m1;
    logic [63:0]        q;
    logic [63:0]        res;
    logic signed [23:0] y;

    assign in_mag = i_in.sample_in[23] ? 24'(~i_in.sample_in + 24'sd1) : i_in.sample_in;
    assign in_idx = CH_AW'(i_in.channel_in);
    assign ch_idx = CH_AW'(r_ch);
    assign sq_y   = 17'(r_prod >> 15);
    assign sl     = (r_slope > 16'd32768) ? 16'd32768 : r_slope;
    assign ex     = 17'(r_lvl - 17'(r_thr));
    assign coef   = (r_t > r_prev) ? r_attack : r_release;
    assign g      = 18'(r_makeup) - $signed({2'b00, r_red});
    assign g_mag  = g[17] ? 18'(-g) : 18'(g);
    assign pl     = r_gneg ? 32'(-r_prod[31:0]) : r_prod[31:0];
    assign neg_l  = {r_sh, 16'b0} - 21'(r_frac);
    assign tgt    = (r_prod[63:15] > 49'(RED_MAX)) ? RED_MAX : r_prod[30:15];
    assign red    = 16'((r_acc + r_prod + 64'd32768) >> 16);
    assign sh_m1  = 6'(7'sd29 - 7'(r_n));
    assign q      = r_prod >> sh_m1;
    assign res    = (q >> 1) + 64'(q[0]);

    always_comb begin
        if (r_neg) begin
            y = (res > 64'd8388608) ? -24'sd8388608 : 24'(-res);
        end else begin
            y = (res > 64'd8388607) ? 24'sd8388607 : 24'(res);
        end
    end

    assign out_load = (r_state == S_OUT_U) && (!r_out_valid || o_out.ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in.valid) n_state = S_NORM;
            S_NORM: begin
                if (r_mag < 24'd9) n_state = S_TGT_M;
                else if (r_norm[23]) n_state = S_SQ_M;
            end
            S_SQ_M:   n_state = S_SQ_U;
            S_SQ_U:   n_state = (r_cnt == 4'd15) ? S_LVL_M : S_SQ_M;
            S_LVL_M:  n_state = S_LVL_U;
            S_LVL_U:  n_state = S_TGT_M;
            S_TGT_M:  n_state = S_TGT_U;
            S_TGT_U:  n_state = S_SM1_M;
            S_SM1_M:  n_state = S_SM2_M;
            S_SM2_M:  n_state = S_SM_U;
            S_SM_U:   n_state = S_GAIN_M;
            S_GAIN_M: n_state = S_GAIN_U;
            S_GAIN_U: n_state = S_POW_M;
            S_POW_M:  n_state = S_POW_U;
            S_POW_U:  n_state = (r_cnt == 4'd15) ? S_OUT_M : S_POW_M;
            S_OUT_M:  n_state = S_OUT_U;
            S_OUT_U:  if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs: handshake and multiplier operands
    always_comb begin
        in_ready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (r_state)
            S_IDLE:   in_ready = 1'b1;
            S_SQ_M: begin
                mul_a = 32'(r_x);
                mul_b = 32'(r_x);
            end
            S_LVL_M: begin
                mul_a = 32'(neg_l);
                mul_b = DB_PER_LOG2;
            end
            S_TGT_M: begin
                mul_a = 32'(ex);
                mul_b = 32'(17'h08000 - 17'(sl));
            end
            S_SM1_M: begin
                mul_a = 32'(coef);
                mul_b = 32'(r_prev);
            end
            S_SM2_M: begin
                mul_a = 32'(17'h10000 - 17'(r_coef));
                mul_b = 32'(r_t);
            end
            S_GAIN_M: begin
                mul_a = 32'(g_mag);
                mul_b = LOG2_PER_DB;
            end
            S_POW_M: begin
                mul_a = 32'(r_p);
                mul_b = 32'(POW_TAB[r_cnt]);
            end
            // product held while the result waits for the output register
            S_OUT_M, S_OUT_U: begin
                mul_a = 32'(r_mag);
                mul_b = 32'(r_p);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_neg  <= i_in.sample_in[23];
                    r_mag  <= in_mag;
                    r_norm <= in_mag;
                    r_sh   <= '0;
                    r_ch   <= i_in.channel_in;
                    r_prev <= ({29'b0, i_in.channel_in} < 32'(CHANNELS)) ? mem[in_idx] : '0;
                end
            end
            S_NORM: begin
                if (r_mag < 24'd9) begin
                    r_lvl <= DB_FLOOR;
                end else if (!r_norm[23]) begin
                    r_norm <= {r_norm[22:0], 1'b0};
                    r_sh   <= r_sh + 5'd1;
                end else begin
                    r_x    <= r_norm[23:8];
                    r_frac <= '0;
                    r_cnt  <= '0;
                end
            end
            S_SQ_U: begin
                if (sq_y[16]) begin
                    r_x <= sq_y[16:1];
                    r_frac[4'd15 - r_cnt] <= 1'b1;
                end else begin
                    r_x <= sq_y[15:0];
                end
                r_cnt <= r_cnt + 4'd1;
            end
            S_LVL_U: r_lvl <= -$signed({1'b0, 16'((r_prod + 64'd8388608) >> 24)});
            S_TGT_M: r_ge <= (r_lvl >= 17'(r_thr));
            S_TGT_U: r_t <= r_ge ? tgt : '0;
            S_SM1_M: r_coef <= coef;
            S_SM2_M: r_acc <= r_prod;
            S_SM_U: begin
                r_red <= red;
                if (i_rst_n && ({29'b0, r_ch} < 32'(CHANNELS))) mem[ch_idx] <= red;
            end
            S_GAIN_M: r_gneg <= g[17];
            S_GAIN_U: begin
                r_n   <= pl[29:24];
                r_f16 <= pl[23:8];
                r_p   <= 31'h4000_0000;
                r_cnt <= '0;
            end
            S_POW_U: begin
                if (r_f16[4'd15 - r_cnt]) r_p <= 31'((r_prod + 64'h2000_0000) >> 30);
                r_cnt <= r_cnt + 4'd1;
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_sample <= y;
            r_out_ch     <= r_ch;
            r_out_red    <= r_red[14:0];
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_thr       <= -16'sd5120;
            r_slope     <= 16'd8192;
            r_makeup    <= '0;
            r_attack    <= 16'd64880;
            r_release   <= 16'd65470;
            for (int i = 0; i < CHANNELS; i++) mem[i] <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_THRESHOLD: r_thr     <= i_cfg.data;
                    CFG_SLOPE:     r_slope   <= i_cfg.data;
                    CFG_MAKEUP:    r_makeup  <= i_cfg.data[13:0];
                    CFG_ATTACK:    r_attack  <= i_cfg.data;
                    CFG_RELEASE:   r_release <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    assign i_in.ready         = in_ready;
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_out_valid;
    assign o_out.sample_out   = r_out_sample;
    assign o_out.channel_out  = r_out_ch;
    assign o_out.reduction_db = r_out_red;

endmodule

// ----- bench/ldac_checker.sv -----
// Checker: watches the compressor's channels, predicts each result and compares.
`timescale 1ns / 1ps
module ldac_checker
    import ldac_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ldac_in_if   in_ch,
    ldac_out_if  out_ch,
    ldac_cfg_if  cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic signed [23:0] sample;
        logic [2:0]         chan;
        logic [14:0]        red;
    } t_comp_result;

    t_comp_result expected_q[$];

    int threshold_v;
    int slope_v;
    int makeup_v;
    int attack_v;
    int release_v;
    logic [15:0] chan_red [CHANNELS];

    int fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_q.size();

    // level in dB Q8.8 from a magnitude
    function automatic int level_of(longint unsigned m);
        int e;
        longint unsigned x;
        longint unsigned frac;
        longint l;
        longint unsigned neg;
        if (m < 9) return int'(DB_FLOOR);
        e = 0;
        for (int i = 0; i < 24; i++)
            if (m[i]) e = i;
        if (e <= 15) x = m << (15 - e);
        else x = m >> (e - 15);
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 15;
            if (x >= 64'd65536) begin
                x = x >> 1;
                frac = frac | (64'd1 << (15 - i));
            end
        end
        l = (longint'(e) - 23) * 65536 + longint'(frac);
        neg = longint'(-l);
        return -int'((neg * 64'd394566 + (64'd1 << 23)) >> 24);
    endfunction

    function automatic t_comp_result compress(logic signed [23:0] s, logic [2:0] ch);
        t_comp_result res_item;
        longint ss;
        longint unsigned mag;
        int lvl;
        longint unsigned sl, t, prev, a, r, ex, v, p, prod, res;
        longint g, pl, n, f;
        longint unsigned f16;
        int sh;
        longint y;
        ss  = s;
        mag = (ss < 0) ? longint'(-ss) : longint'(ss);
        lvl = level_of(mag);
        sl  = (slope_v > 32768) ? 64'd32768 : longint'(slope_v);
        t   = 0;
        if (lvl >= threshold_v) begin
            ex = longint'(lvl) - longint'(threshold_v);
            v  = (ex * (64'd32768 - sl)) >> 15;
            t  = (v > 64'd30720) ? 64'd30720 : v;
        end
        prev = (int'(ch) < CHANNELS) ? longint'(chan_red[ch]) : 64'd0;
        a    = (t > prev) ? longint'(attack_v) : longint'(release_v);
        r    = (a * prev + (64'd65536 - a) * t + 64'd32768) >> 16;
        if (int'(ch) < CHANNELS) chan_red[ch] = r[15:0];

        g  = longint'(makeup_v) - longint'(r);
        pl = g * 10885;
        n  = pl >>> 24;
        f  = pl - n * 16777216;
        f16 = (longint'(f) >> 8) & 64'hFFFF;
        p = 64'd1 << 30;
        for (int i = 0; i < 16; i++)
            if (f16[15 - i]) p = (p * longint'(POW_TAB[i]) + (64'd1 << 29)) >> 30;
        sh   = 30 - int'(n);
        prod = mag * p;
        res  = (prod >> sh) + ((prod >> (sh - 1)) & 64'd1);
        if (ss < 0) y = (res > 64'd8388608) ? -64'sd8388608 : -longint'(res);
        else y = (res > 64'd8388607) ? 64'sd8388607 : longint'(res);

        res_item.sample = y[23:0];
        res_item.chan   = ch;
        res_item.red    = r[14:0];
        return res_item;
    endfunction

    always @(posedge i_clk) begin
        t_comp_result want;
        t_comp_result got;
        if (!i_rst_n) begin
            threshold_v = -5120;
            slope_v     = 8192;
            makeup_v    = 0;
            attack_v    = 64880;
            release_v   = 65470;
            for (int i = 0; i < CHANNELS; i++) chan_red[i] = '0;
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_THRESHOLD: threshold_v = int'($signed(cfg_ch.data));
                    CFG_SLOPE:     slope_v     = int'(cfg_ch.data);
                    CFG_MAKEUP:    makeup_v    = int'($signed(cfg_ch.data[13:0]));
                    CFG_ATTACK:    attack_v    = int'(cfg_ch.data);
                    CFG_RELEASE:   release_v   = int'(cfg_ch.data);
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got.sample = out_ch.sample_out;
                got.chan   = out_ch.channel_out;
                got.red    = out_ch.reduction_db;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: sample %0d ch %0d red %0d",
                                 got.sample, got.chan, got.red);
                end else begin
                    want = expected_q.pop_front();
                    if (want != got) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp sample %0d ch %0d red %0d, got %0d %0d %0d",
                                     want.sample, want.chan, want.red,
                                     got.sample, got.chan, got.red);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(compress(in_ch.sample_in, in_ch.channel_in));
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top: clock, reset, stimulus for the compressor and the verdict.
`timescale 1ns / 1ps
module tb
    import ldac_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 210;
    localparam logic [2:0] CFG_SPARE_A = 3'd5;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   quiet_cycles;

    ldac_in_if  in_if ();
    ldac_out_if out_if ();
    ldac_cfg_if cfg_if ();

    log_domain_audio_compressor uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    ldac_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_if),
        .out_ch       (out_if),
        .cfg_ch       (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else out_if.ready <= calm || ($urandom_range(99) >= 30);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // each call starts and ends at a falling edge
    task automatic send_sample(input logic signed [23:0] s, input logic [2:0] ch);
        if (!calm && $urandom_range(99) < 30) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.sample_in  <= s;
        in_if.channel_in <= ch;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain;
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_all(input int thr, input int slp, input int mk,
                             input int att, input int rel);
        write_reg(CFG_THRESHOLD, 16'(thr));
        write_reg(CFG_SLOPE, 16'(slp));
        write_reg(CFG_MAKEUP, 16'(mk));
        write_reg(CFG_ATTACK, 16'(att));
        write_reg(CFG_RELEASE, 16'(rel));
    endtask

    function automatic logic signed [23:0] random_sample();
        int m;
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: m = $urandom_range(0, 8388607) >> $urandom_range(0, 23);
            2: m = $urandom_range(0, 20);
            default: m = $urandom_range(8000000, 8388607);
        endcase
        return $urandom_range(1) ? -24'(m) : 24'(m);
    endfunction

    task automatic random_run(input int count);
        logic [2:0] ch;
        for (int i = 0; i < count; i++) begin
            ch = $urandom_range(1) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
            send_sample(random_sample(), ch);
        end
    endtask

    task automatic directed_run;
        logic signed [23:0] pick [12] = '{
            24'sd0, 24'sd1, 24'sd8, 24'sd9, -24'sd9, -24'sd1, 24'sd8388607,
            -24'sd8388608, 24'sd4194304, -24'sd4194305, 24'sd12345, -24'sd8
        };
        for (int i = 0; i < 12; i++) send_sample(pick[i], 3'(i));
    endtask

    initial begin
        i_rst_n          = 1'b0;
        calm             = 1'b0;
        in_if.valid      = 1'b0;
        in_if.sample_in  = '0;
        in_if.channel_in = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        out_if.ready     = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_run();
        drain();
        // extremes: lowest threshold, no slope, so large excess saturates
        write_all(-30720, 0, 6144, 0, 0);
        directed_run();
        random_run(PHASE_ITEMS);
        drain();
        write_all(0, 32768, -6144, 65535, 65535);
        directed_run();
        random_run(PHASE_ITEMS);
        drain();
        // slope above unity acts as no reduction; spare indexes are ignored
        write_all(-$urandom_range(0, 30720), 40000, $urandom_range(0, 12288) - 6144,
                  $urandom_range(65535), $urandom_range(65535));
        write_reg(CFG_SPARE_A, 16'($urandom));
        write_reg(CFG_SPARE_B, 16'($urandom));
        random_run(PHASE_ITEMS);
        drain();
        write_reg(CFG_SLOPE, 16'hFFFF);
        random_run(PHASE_ITEMS / 2);
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            calm = (ph == 1);
            write_all(-$urandom_range(0, 30720), $urandom_range(0, 32768),
                      $urandom_range(0, 12288) - 6144, $urandom_range(65535),
                      $urandom_range(65535));
            random_run(PHASE_ITEMS);
            drain();
        end
        calm = 1'b0;
        repeat (200) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
